[hw/rtl/psu_pkg.sv]
package psu_pkg;

    // Fixed widths of the configuration registers
    localparam int GRID_W     = 10;
    localparam int LIMIT_W    = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_LINES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [GRID_W-1:0]  GRID_LINES_RST = 10'd8;
    localparam logic               METHOD_RST     = 1'b0;
    localparam logic [LIMIT_W-1:0] PRECISION_RST  = 31'd1074;

    // Relaxation method codes
    localparam logic METHOD_JACOBI = 1'b0;
    localparam logic METHOD_GAUSS  = 1'b1;

    // Per-item control that follows an accepted beat through the datapath
    typedef struct packed {
        logic produce;     // beat completes an interior cell
        logic is_last;     // final interior cell of the sweep
        logic new_up;      // take upper neighbor from the fresh line
        logic new_left;    // take left neighbor from the fresh value
        logic clear_peak;  // first position of a sweep
    } item_flags_t;

endpackage

[hw/rtl/poisson_stencil_sweep_unit.sv]
// Channel  Direction  Payload
// s_*      in         tdata: cell_value, forcing
// m_*      out        tdata: new_value, max_residuum, converged; tlast: last
// cfg_*    in         write: grid_lines (0), method (1), precision_limit (2)
//
// One beat is taken per cycle while no configuration write or stall holds it;
// a result leaves via input, then result register, after the cell below it.
// Line buffers are read one beat ahead on registered RAM ports, so input is
// held off during each configuration write and in the cycle after it.
// Reset clears positions, the peak and the fresh left value; the line
// buffers are not cleared. An output stall holds the beat in the input stage.
module poisson_stencil_sweep_unit #(
    parameter int MAX_LINE    = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [psu_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [psu_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cell_value, forcing
    input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // new_value, max_residuum, converged
    output logic [((2*VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic                              m_tlast
);

    localparam int W     = VALUE_WIDTH;
    localparam int PW    = $clog2(MAX_LINE);
    localparam int BUS_W = ((2 * W + 7) / 8) * 8;

    // Configuration registers
    logic [psu_pkg::GRID_W-1:0]  grid_lines_reg;
    logic                        method_reg;
    logic [psu_pkg::LIMIT_W-1:0] limit_reg;
    logic                        cfg_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_lines_reg <= psu_pkg::GRID_LINES_RST;
            method_reg     <= psu_pkg::METHOD_RST;
            limit_reg      <= psu_pkg::PRECISION_RST;
            cfg_hold_reg   <= 1'b0;
        end
        else
        begin
            cfg_hold_reg <= cfg_wr_en;
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    psu_pkg::CFG_GRID_LINES: grid_lines_reg <= cfg_wr_data[psu_pkg::GRID_W-1:0];
                    psu_pkg::CFG_METHOD:     method_reg     <= cfg_wr_data[0];
                    psu_pkg::CFG_PRECISION:  limit_reg      <= cfg_wr_data[psu_pkg::LIMIT_W-1:0];
                    default:                 ;
                endcase
            end
        end
    end

    // Handshake
    logic                 accept;
    logic                 s1_fire;
    logic                 s1_valid_reg;
    psu_pkg::item_flags_t s1_flags_reg;
    logic                 out_valid_reg;

    assign s1_fire  = s1_valid_reg && (!s1_flags_reg.produce || !out_valid_reg || m_tready);
    assign s_tready = !cfg_wr_en && !cfg_hold_reg && (!s1_valid_reg || s1_fire);
    assign accept   = s_tvalid && s_tready;

    logic [W-1:0] in_cell;
    logic [W-1:0] in_forcing;

    assign in_cell    = s_tdata[W-1:0];
    assign in_forcing = s_tdata[2*W-1:W];

    // Raster position and line buffer addressing
    logic [PW-1:0]        pos_col;
    logic [PW-1:0]        rd_col;
    logic [PW-1:0]        rd_col_right;
    psu_pkg::item_flags_t pos_flags;

    psu_seq #(
        .MAX_LINE (MAX_LINE)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .grid_lines   (grid_lines_reg),
        .method       (method_reg),
        .advance      (accept),
        .col          (pos_col),
        .rd_col       (rd_col),
        .rd_col_right (rd_col_right),
        .flags        (pos_flags)
    );

    // Line buffers
    logic [W-1:0] centre_q;
    logic [W-1:0] right_q;
    logic [W-1:0] up_q;
    logic [W-1:0] up_new_q;
    logic [W-1:0] forcing_q;
    logic [W-1:0] star;
    logic [PW-1:0] s1_col_reg;

    psu_ram #(.WIDTH (W), .DEPTH (MAX_LINE)) u_center_a (
        .clk (clk), .wr_en (accept), .wr_addr (pos_col), .wr_data (in_cell),
        .rd_addr (rd_col), .rd_data (centre_q)
    );

    psu_ram #(.WIDTH (W), .DEPTH (MAX_LINE)) u_center_b (
        .clk (clk), .wr_en (accept), .wr_addr (pos_col), .wr_data (in_cell),
        .rd_addr (rd_col_right), .rd_data (right_q)
    );

    psu_ram #(.WIDTH (W), .DEPTH (MAX_LINE)) u_upper (
        .clk (clk), .wr_en (accept), .wr_addr (pos_col), .wr_data (centre_q),
        .rd_addr (rd_col), .rd_data (up_q)
    );

    psu_ram #(.WIDTH (W), .DEPTH (MAX_LINE)) u_fresh (
        .clk (clk), .wr_en (s1_fire && s1_flags_reg.produce), .wr_addr (s1_col_reg),
        .wr_data (star), .rd_addr (rd_col), .rd_data (up_new_q)
    );

    psu_ram #(.WIDTH (W), .DEPTH (MAX_LINE)) u_forcing (
        .clk (clk), .wr_en (accept), .wr_addr (pos_col), .wr_data (in_forcing),
        .rd_addr (rd_col), .rd_data (forcing_q)
    );

    // Input stage: beat plus its neighborhood
    logic [W-1:0] prev_centre_reg;
    logic [W-1:0] s1_cell_reg;
    logic [W-1:0] s1_centre_reg;
    logic [W-1:0] s1_right_reg;
    logic [W-1:0] s1_up_reg;
    logic [W-1:0] s1_up_new_reg;
    logic [W-1:0] s1_left_reg;
    logic [W-1:0] s1_forcing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_flags_reg <= '0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_flags_reg <= pos_flags;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_centre_reg <= centre_q;
            s1_cell_reg     <= in_cell;
            s1_centre_reg   <= centre_q;
            s1_right_reg    <= right_q;
            s1_up_reg       <= up_q;
            s1_up_new_reg   <= up_new_q;
            s1_left_reg     <= prev_centre_reg;
            s1_forcing_reg  <= forcing_q;
            s1_col_reg      <= pos_col;
        end
    end

    // Stencil, residuum and convergence
    logic [W-2:0] peak;
    logic         conv;

    psu_relax #(
        .VALUE_WIDTH (W)
    ) u_relax (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (s1_fire),
        .flags           (s1_flags_reg),
        .below           (s1_cell_reg),
        .centre          (s1_centre_reg),
        .right           (s1_right_reg),
        .up_old          (s1_up_reg),
        .up_new          (s1_up_new_reg),
        .left_old        (s1_left_reg),
        .forcing         (s1_forcing_reg),
        .precision_limit (limit_reg),
        .new_value       (star),
        .max_residuum    (peak),
        .converged       (conv)
    );

    // Result register
    logic [W-1:0] out_value_reg;
    logic [W-2:0] out_peak_reg;
    logic         out_conv_reg;
    logic         out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_flags_reg.produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_flags_reg.produce)
        begin
            out_value_reg <= star;
            out_peak_reg  <= peak;
            out_conv_reg  <= conv;
            out_last_reg  <= s1_flags_reg.is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = BUS_W'({out_conv_reg, out_peak_reg, out_value_reg});
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // A held input stage never lets a new beat in
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |-> !s_tready)
        else $error("input stage overwritten while held");

    // A completed interior cell always reaches the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_flags_reg.produce |=> out_valid_reg)
        else $error("completed cell lost");

    // Convergence is only reported with the final cell
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_conv_reg |-> out_last_reg)
        else $error("convergence flagged before final cell");
`endif

endmodule

[hw/rtl/psu_ram.sv]
module psu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    // One write port, one registered read port; a read of the address being
    // written returns the new data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_reg <= wr_data;
        end
        else
        begin
            rd_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_reg;

endmodule

[hw/rtl/psu_seq.sv]
module psu_seq #(
    parameter int MAX_LINE = 1024,
    localparam int PW = $clog2(MAX_LINE)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [psu_pkg::GRID_W-1:0]   grid_lines,
    input  logic                         method,
    input  logic                         advance,
    output logic [PW-1:0]                col,
    output logic [PW-1:0]                rd_col,
    output logic [PW-1:0]                rd_col_right,
    output psu_pkg::item_flags_t         flags
);

    localparam int CW = (PW > psu_pkg::GRID_W) ? PW : psu_pkg::GRID_W;
    localparam logic [CW-1:0] N_CAP = CW'(MAX_LINE - 1);

    logic [PW-1:0] row_reg, row_next;
    logic [PW-1:0] col_reg, col_next;
    logic [CW-1:0] n_wide;
    logic [PW-1:0] n;
    logic [PW-1:0] r;
    logic [PW-1:0] c;

    // Grid size limited to the line buffer depth
    always_comb
    begin
        n_wide = CW'(grid_lines);
        if (n_wide > N_CAP)
        begin
            n = PW'(N_CAP);
        end
        else
        begin
            n = PW'(n_wide);
        end
    end

    // A position beyond a shrunken grid restarts the sweep
    always_comb
    begin
        if ((row_reg > n) || (col_reg > n))
        begin
            r = '0;
            c = '0;
        end
        else
        begin
            r = row_reg;
            c = col_reg;
        end
    end

    // Raster advance with wrap at the grid edge
    always_comb
    begin
        row_next = r;
        col_next = c + PW'(1);
        if (c >= n)
        begin
            col_next = '0;
            if (r >= n)
            begin
                row_next = '0;
            end
            else
            begin
                row_next = r + PW'(1);
            end
        end
    end

    // Classification of the current position
    always_comb
    begin
        flags.produce    = (n >= PW'(2)) && (r >= PW'(2)) && (c >= PW'(1))
                           && (c <= n - PW'(1));
        flags.is_last    = flags.produce && (r == n) && (c == n - PW'(1));
        flags.new_up     = (method == psu_pkg::METHOD_GAUSS) && (r > PW'(2));
        flags.new_left   = (method == psu_pkg::METHOD_GAUSS) && (c > PW'(1));
        flags.clear_peak = (r == '0) && (c == '0);
    end

    // Line buffers are read for the position of the next beat to arrive
    assign col          = c;
    assign rd_col       = advance ? col_next : c;
    assign rd_col_right = rd_col + PW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (advance)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

[hw/rtl/psu_relax.sv]
module psu_relax #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  psu_pkg::item_flags_t          flags,
    input  logic [VALUE_WIDTH-1:0]        below,
    input  logic [VALUE_WIDTH-1:0]        centre,
    input  logic [VALUE_WIDTH-1:0]        right,
    input  logic [VALUE_WIDTH-1:0]        up_old,
    input  logic [VALUE_WIDTH-1:0]        up_new,
    input  logic [VALUE_WIDTH-1:0]        left_old,
    input  logic [VALUE_WIDTH-1:0]        forcing,
    input  logic [psu_pkg::LIMIT_W-1:0]   precision_limit,
    output logic [VALUE_WIDTH-1:0]        new_value,
    output logic [VALUE_WIDTH-2:0]        max_residuum,
    output logic                          converged
);

    localparam int W  = VALUE_WIDTH;
    localparam int LW = (W - 1 > psu_pkg::LIMIT_W) ? W - 1 : psu_pkg::LIMIT_W;
    localparam logic [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]   left_new_reg;
    logic [W-2:0]   peak_reg, peak_next;
    logic [W-1:0]   up;
    logic [W-1:0]   left;
    logic [W+1:0]   sum_w;
    logic [W-1:0]   quarter;
    logic [W:0]     star_w;
    logic [W-1:0]   star;
    logic [W:0]     diff_w;
    logic [W:0]     mag;
    logic [W-2:0]   mag_sat;
    logic [W-2:0]   peak_base;

    // Neighbor selection: fresh values in Gauss-Seidel mode
    assign up   = flags.new_up ? up_new : up_old;
    assign left = flags.new_left ? left_new_reg : left_old;

    // Quarter of the exact neighbor sum (floor), plus forcing, saturated
    always_comb
    begin
        sum_w   = {{2{up[W-1]}}, up} + {{2{left[W-1]}}, left}
                  + {{2{right[W-1]}}, right} + {{2{below[W-1]}}, below};
        quarter = sum_w[W+1:2];
        star_w  = {quarter[W-1], quarter} + {forcing[W-1], forcing};
        if (star_w[W] != star_w[W-1])
        begin
            star = star_w[W] ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            star = star_w[W-1:0];
        end
    end

    // Absolute change against the old center, saturated, and running peak
    always_comb
    begin
        diff_w = {centre[W-1], centre} - {star[W-1], star};
        mag    = diff_w[W] ? (~diff_w + {{W{1'b0}}, 1'b1}) : diff_w;
        if (mag[W:W-1] != 2'b00)
        begin
            mag_sat = '1;
        end
        else
        begin
            mag_sat = mag[W-2:0];
        end
        peak_base = flags.clear_peak ? '0 : peak_reg;
        if (flags.produce && (mag_sat > peak_base))
        begin
            peak_next = mag_sat;
        end
        else
        begin
            peak_next = peak_base;
        end
    end

    assign new_value    = star;
    assign max_residuum = peak_next;
    assign converged    = flags.is_last && (LW'(peak_next) < LW'(precision_limit));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_new_reg <= '0;
            peak_reg     <= '0;
        end
        else if (fire)
        begin
            peak_reg <= peak_next;
            if (flags.produce)
            begin
                left_new_reg <= star;
            end
        end
    end

endmodule
